// ===== hdl/vic_pkg.sv =====
`timescale 1ns / 1ps

package vic_pkg;

  localparam int unsigned NumLines        = 32;
  localparam int unsigned LineIdxW        = 5;
  localparam int unsigned DataW           = 32;
  localparam int unsigned EdgeDefaultLine = 0;

  localparam logic [DataW-1:0] TopBit    = 32'h8000_0000;
  localparam logic [DataW-1:0] BaseMask  = 32'hffff_fffc;
  localparam logic [DataW-1:0] AllOnes   = 32'hffff_ffff;
  localparam logic [DataW-1:0] OrderBit  = 32'h0000_0001;
  localparam int unsigned      VecShift  = 9;  // vector step of 512

  localparam logic [DataW-1:0] TriggerReset = TopBit >> EdgeDefaultLine;

  // APB address of the line_invert register, in words
  localparam int unsigned      PaddrW         = 3;
  localparam logic             CfgLineInvert  = 1'b0;

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    REG_STATUS   = 4'd0,
    REG_ENABLE   = 4'd1,
    REG_CRITICAL = 4'd2,
    REG_POLARITY = 4'd3,
    REG_TRIGGER  = 4'd4,
    REG_MASKED   = 4'd5,
    REG_VECCFG   = 4'd6,
    REG_VECTOR   = 4'd7,
    REG_LEVELS   = 4'd8
  } reg_sel_e;

endpackage

// ===== hdl/vectored_interrupt_controller_top.sv =====
`timescale 1ns / 1ps

// Vectored interrupt controller for 32 lines, line 0 in bit 31. Each input
// transfer is either a change on one line (kind 0), a register write (kind 1)
// or a register read (kind 2); kind 3 is a no-op. Every accepted transfer
// yields exactly one result transfer carrying read_data (zero unless a read)
// and the critical / noncritical request levels after the update. The block
// takes one transfer per clock while in_ready_o is high: the state update
// and the result are formed in one pass of combinational logic and land in
// the state registers and the single output register at the accepting edge,
// so the result appears in the next cycle. in_ready_o stays high while the
// output register is empty or being drained, so a stalled consumer stalls
// the input only once the output register holds an untaken result. The
// vector read (register 7) is the vector base plus 512 times the index of
// the highest-priority pending critical line; vector_config bit 0 picks
// counting from bit 31 down (set) or from bit 0 up (clear). The APB port
// holds the line_invert register at byte address 0; writing it also loads
// the stored line levels. Reconfigure only while no transfer is in flight.
module vectored_interrupt_controller_top import vic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [LineIdxW-1:0] line_index_i,
  input  logic                line_level_i,
  input  logic [3:0]          reg_select_i,
  input  logic [DataW-1:0]    write_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DataW-1:0]    read_data_o,
  output logic                critical_irq_o,
  output logic                noncritical_irq_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  // Controller state
  logic [DataW-1:0] line_invert_q, line_invert_d;
  logic [DataW-1:0] status_q,      status_d;
  logic [DataW-1:0] enable_q,      enable_d;
  logic [DataW-1:0] critical_q,    critical_d;
  logic [DataW-1:0] polarity_q,    polarity_d;
  logic [DataW-1:0] trigger_q,     trigger_d;
  logic [DataW-1:0] veccfg_q,      veccfg_d;
  logic [DataW-1:0] levels_q,      levels_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] rdata_q,     rdata_d;
  logic             crit_q,      crit_d;
  logic             noncrit_q,   noncrit_d;

  logic             in_xfer;
  logic             cfg_wr;
  logic [DataW-1:0] line_bit;
  logic             line_up;
  logic             line_cur;
  logic [DataW-1:0] masked;
  logic [DataW-1:0] pend;
  logic [LineIdxW-1:0] vec_idx;
  logic [DataW-1:0] vector;
  logic [DataW-1:0] read_val;
  logic [DataW-1:0] masked_d;

  // Handshakes: accept while the output slot is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PaddrW-1:2] == CfgLineInvert);
  assign prdata = (paddr[PaddrW-1:2] == CfgLineInvert) ? line_invert_q : '0;

  // Line change decode: line n sits in bit 31-n
  assign line_bit = TopBit >> line_index_i;
  assign line_up  = line_level_i ^ (|(line_invert_q & line_bit));
  assign line_cur = |(levels_q & line_bit);

  // Priority encode of pending critical lines
  assign masked = status_q & enable_q;
  assign pend   = masked & critical_q;

  always_comb begin
    vec_idx = '0;
    if ((veccfg_q & OrderBit) != '0) begin
      // count from bit 31 down: highest set bit wins
      for (int i = 0; i < NumLines; i++) begin
        if (pend[i]) vec_idx = LineIdxW'(NumLines - 1 - i);
      end
    end else begin
      // count from bit 0 up: lowest set bit wins
      for (int i = NumLines - 1; i >= 0; i--) begin
        if (pend[i]) vec_idx = LineIdxW'(i);
      end
    end
  end

  assign vector = (pend == '0) ? '0
                : (veccfg_q & BaseMask) + (DataW'(vec_idx) << VecShift);

  always_comb begin
    unique case (reg_select_i)
      REG_STATUS:   read_val = status_q;
      REG_ENABLE:   read_val = enable_q;
      REG_CRITICAL: read_val = critical_q;
      REG_POLARITY: read_val = polarity_q;
      REG_TRIGGER:  read_val = trigger_q;
      REG_MASKED:   read_val = masked;
      REG_VECCFG:   read_val = veccfg_q;
      REG_VECTOR:   read_val = vector;
      REG_LEVELS:   read_val = levels_q;
      default:      read_val = '0;
    endcase
  end

  // State update for one accepted transfer
  always_comb begin
    line_invert_d = line_invert_q;
    status_d      = status_q;
    enable_d      = enable_q;
    critical_d    = critical_q;
    polarity_d    = polarity_q;
    trigger_d     = trigger_q;
    veccfg_d      = veccfg_q;
    levels_d      = levels_q;

    if (in_xfer) begin
      case (kind_i)
        KIND_LINE: begin
          if (line_up != line_cur) begin
            levels_d = line_up ? (levels_q | line_bit) : (levels_q & ~line_bit);
            // latch only on a transition toward the polarity
            if (line_up == (|(polarity_q & line_bit))) status_d = status_q | line_bit;
          end
        end
        KIND_WRITE: begin
          unique case (reg_select_i)
            // clear ones written, but hold level lines still active
            REG_STATUS:   status_d = status_q &
                            ~(write_data_i & (trigger_q | (levels_q ^ polarity_q)));
            REG_ENABLE:   enable_d   = write_data_i;
            REG_CRITICAL: critical_d = write_data_i;
            REG_POLARITY: polarity_d = write_data_i;
            REG_TRIGGER:  trigger_d  = write_data_i;
            REG_VECCFG:   veccfg_d   = write_data_i;
            default:      ;
          endcase
        end
        default: ;
      endcase
    end

    if (cfg_wr) begin
      line_invert_d = pwdata;
      levels_d      = pwdata;
    end
  end

  // Result formed from the updated state
  assign masked_d = status_d & enable_d;

  always_comb begin
    out_valid_d = out_valid_q;
    rdata_d     = rdata_q;
    crit_d      = crit_q;
    noncrit_d   = noncrit_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (in_xfer) begin
      out_valid_d = 1'b1;
      rdata_d     = (kind_i == KIND_READ) ? read_val : '0;
      crit_d      = |(masked_d & critical_d);
      noncrit_d   = |(masked_d & ~critical_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_invert_q <= '0;
      status_q      <= '0;
      enable_q      <= '0;
      critical_q    <= '0;
      polarity_q    <= AllOnes;
      trigger_q     <= TriggerReset;
      veccfg_q      <= '0;
      levels_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      line_invert_q <= line_invert_d;
      status_q      <= status_d;
      enable_q      <= enable_d;
      critical_q    <= critical_d;
      polarity_q    <= polarity_d;
      trigger_q     <= trigger_d;
      veccfg_q      <= veccfg_d;
      levels_q      <= levels_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk_i) begin
    rdata_q   <= rdata_d;
    crit_q    <= crit_d;
    noncrit_q <= noncrit_d;
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = rdata_q;
  assign critical_irq_o    = crit_q;
  assign noncritical_irq_o = noncrit_q;

endmodule

// ===== hdl/vic_checker.sv =====
`timescale 1ns / 1ps

module vic_checker import vic_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          kind_i,
  input logic [LineIdxW-1:0] line_index_i,
  input logic                line_level_i,
  input logic [3:0]          reg_select_i,
  input logic [DataW-1:0]    write_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [DataW-1:0]    read_data_o,
  input logic                critical_irq_o,
  input logic                noncritical_irq_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [PaddrW-1:0]   paddr,
  input logic [DataW-1:0]    pwdata,
  input logic [DataW-1:0]    prdata,
  input logic                pready
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(read_data_o) && $stable(critical_irq_o)
      && $stable(noncritical_irq_o))
    else $error("stalled result changed");

  // Every accepted transfer shows its result in the next cycle
  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("no result after accepted transfer");

  // Only reads return data
  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && kind_i != KIND_READ |=> read_data_o == '0)
    else $error("nonzero read_data on non-read");

  // Disabling all lines drops both requests
  a_enable_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && kind_i == KIND_WRITE && reg_select_i == REG_ENABLE && write_data_i == '0
      |=> !critical_irq_o && !noncritical_irq_o)
    else $error("request with all lines disabled");

  // No critical lines means no critical request
  a_crit_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && kind_i == KIND_WRITE && reg_select_i == REG_CRITICAL && write_data_i == '0
      |=> !critical_irq_o)
    else $error("critical request with no critical lines");

endmodule

bind vectored_interrupt_controller_top vic_checker u_vic_checker (.*);

// ===== bench/tb_vectored_interrupt_controller_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the vectored interrupt controller. A mirror of the
// controller state predicts one result per accepted input transfer; results are
// compared field by field, in order, against the queue of predictions.
module tb_vectored_interrupt_controller_top;
  import vic_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandomPerPhase = 110;
  localparam int unsigned NumPhases = 4;
  localparam int unsigned MaxReports = 10;
  // A select code above the last defined register.
  localparam logic [3:0] RegUnknown = 4'd15;
  localparam logic [PaddrW-1:0] LineInvertAddr = PaddrW'(4 * int'(CfgLineInvert));

  typedef struct packed {
    logic [1:0]          kind;
    logic [LineIdxW-1:0] idx;
    logic                lvl;
    logic [3:0]          sel;
    logic [DataW-1:0]    data;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] rd;
    logic             crit;
    logic             noncrit;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    known;
    result_t exp;
  } row_t;

  localparam result_t NoIrq = '{'0, 1'b0, 1'b0};

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          kind_i;
  logic [LineIdxW-1:0] line_index_i;
  logic                line_level_i;
  logic [3:0]          reg_select_i;
  logic [DataW-1:0]    write_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [DataW-1:0]    read_data_o;
  logic                critical_irq_o;
  logic                noncritical_irq_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  vectored_interrupt_controller_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .line_index_i      (line_index_i),
    .line_level_i      (line_level_i),
    .reg_select_i      (reg_select_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_data_o       (read_data_o),
    .critical_irq_o    (critical_irq_o),
    .noncritical_irq_o (noncritical_irq_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Mirror of the controller state, advanced once per accepted transfer.
  logic [DataW-1:0] invert_mirror;
  logic [DataW-1:0] status_mirror;
  logic [DataW-1:0] enable_mirror;
  logic [DataW-1:0] critical_mirror;
  logic [DataW-1:0] polarity_mirror;
  logic [DataW-1:0] trigger_mirror;
  logic [DataW-1:0] veccfg_mirror;
  logic [DataW-1:0] levels_mirror;

  result_t     results_due[$];
  int unsigned mismatches;
  int unsigned sent_count;
  int unsigned taken_count;
  int unsigned idle_cycles;
  bit          src_burst;
  bit          sink_burst;

  // Opening sequence, run right after reset with line_invert still at zero.
  // Rows with known set carry a hand-worked result; the rest use the mirror.
  row_t opening_rows[25] = '{
    // reset values
    '{'{KIND_READ, 5'd0, 1'b0, REG_STATUS, '0}, 1'b1, NoIrq},
    '{'{KIND_READ, 5'd0, 1'b0, REG_POLARITY, '0}, 1'b1, '{AllOnes, 1'b0, 1'b0}},
    '{'{KIND_READ, 5'd0, 1'b0, REG_TRIGGER, '0}, 1'b1, '{TriggerReset, 1'b0, 1'b0}},
    '{'{KIND_READ, 5'd0, 1'b0, REG_LEVELS, '0}, 1'b1, NoIrq},
    // no critical line pending gives a zero vector
    '{'{KIND_READ, 5'd0, 1'b0, REG_VECTOR, '0}, 1'b1, NoIrq},
    // unknown register and unknown kind read as zero and change nothing
    '{'{KIND_READ, 5'd0, 1'b0, RegUnknown, '0}, 1'b1, NoIrq},
    '{'{KIND_NONE, 5'd31, 1'b1, REG_ENABLE, AllOnes}, 1'b1, NoIrq},
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_ENABLE, AllOnes}, 1'b1, NoIrq},
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_CRITICAL, OrderBit}, 1'b1, NoIrq},
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_VECCFG, AllOnes}, 1'b1, NoIrq},
    // rising edge on line 0, enabled and noncritical
    '{'{KIND_LINE, 5'd0, 1'b1, '0, '0}, 1'b1, '{'0, 1'b0, 1'b1}},
    // same level again does nothing
    '{'{KIND_LINE, 5'd0, 1'b1, '0, '0}, 1'b0, NoIrq},
    '{'{KIND_LINE, 5'd31, 1'b1, '0, '0}, 1'b0, NoIrq},
    // msb-first vector with the top base, sum wraps; then lsb-first, base 0x400
    '{'{KIND_READ, 5'd0, 1'b0, REG_VECTOR, '0}, 1'b0, NoIrq},
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_VECCFG, 32'h0000_0402}, 1'b0, NoIrq},
    '{'{KIND_READ, 5'd0, 1'b0, REG_VECTOR, '0}, 1'b0, NoIrq},
    // level line still active survives a status clear
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_STATUS, AllOnes}, 1'b0, NoIrq},
    '{'{KIND_LINE, 5'd31, 1'b0, '0, '0}, 1'b0, NoIrq},
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_STATUS, AllOnes}, 1'b0, NoIrq},
    // falling-edge polarity
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_POLARITY, '0}, 1'b0, NoIrq},
    '{'{KIND_LINE, 5'd5, 1'b1, '0, '0}, 1'b0, NoIrq},
    '{'{KIND_LINE, 5'd5, 1'b0, '0, '0}, 1'b0, NoIrq},
    // read-only register ignores the write
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_MASKED, AllOnes}, 1'b0, NoIrq},
    '{'{KIND_WRITE, 5'd0, 1'b0, REG_TRIGGER, '0}, 1'b0, NoIrq},
    '{'{KIND_READ, 5'd0, 1'b0, REG_LEVELS, '0}, 1'b0, NoIrq}
  };

  // Vector read: base plus 512 times the rank of the winning critical line.
  function automatic logic [DataW-1:0] vector_mirror();
    logic [DataW-1:0] pend;
    logic [DataW-1:0] rank;
    logic             msb_first;
    pend = status_mirror & enable_mirror & critical_mirror;
    rank = '0;
    msb_first = (veccfg_mirror & OrderBit) != '0;
    if (pend == '0) return '0;
    for (int b = 0; b < NumLines; b++) begin
      if (msb_first ? pend[NumLines-1-b] : pend[b]) begin
        rank = DataW'(b);
        break;
      end
    end
    return (veccfg_mirror & BaseMask) + (rank << VecShift);
  endfunction

  // Advance the mirror by one transfer and return the result it produces.
  function automatic result_t step_controller(item_t it);
    result_t          res;
    logic [DataW-1:0] bit_sel;
    logic             up;
    logic [DataW-1:0] masked;
    res = NoIrq;
    bit_sel = TopBit >> it.idx;
    case (it.kind)
      KIND_LINE: begin
        up = it.lvl ^ ((invert_mirror & bit_sel) != '0);
        if (up != ((levels_mirror & bit_sel) != '0)) begin
          levels_mirror = up ? (levels_mirror | bit_sel) : (levels_mirror & ~bit_sel);
          // latch only on a move toward the polarity
          if (up == ((polarity_mirror & bit_sel) != '0)) status_mirror |= bit_sel;
        end
      end
      KIND_WRITE: begin
        case (it.sel)
          REG_STATUS: status_mirror &=
              ~(it.data & (trigger_mirror | (levels_mirror ^ polarity_mirror)));
          REG_ENABLE:   enable_mirror = it.data;
          REG_CRITICAL: critical_mirror = it.data;
          REG_POLARITY: polarity_mirror = it.data;
          REG_TRIGGER:  trigger_mirror = it.data;
          REG_VECCFG:   veccfg_mirror = it.data;
          default: ;
        endcase
      end
      KIND_READ: begin
        case (it.sel)
          REG_STATUS:   res.rd = status_mirror;
          REG_ENABLE:   res.rd = enable_mirror;
          REG_CRITICAL: res.rd = critical_mirror;
          REG_POLARITY: res.rd = polarity_mirror;
          REG_TRIGGER:  res.rd = trigger_mirror;
          REG_MASKED:   res.rd = status_mirror & enable_mirror;
          REG_VECCFG:   res.rd = veccfg_mirror;
          REG_VECTOR:   res.rd = vector_mirror();
          REG_LEVELS:   res.rd = levels_mirror;
          default:      res.rd = '0;
        endcase
      end
      default: ;
    endcase
    masked = status_mirror & enable_mirror;
    res.crit = (masked & critical_mirror) != '0;
    res.noncrit = (masked & ~critical_mirror) != '0;
    return res;
  endfunction

  function automatic logic [DataW-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return AllOnes;
      2: return TopBit >> $urandom_range(0, NumLines - 1);
      default: return $urandom;
    endcase
  endfunction

  // Mostly line changes and writes that keep requests moving, some reads,
  // a few unknown selects and no-op kinds.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.idx = LineIdxW'($urandom_range(0, NumLines - 1));
    it.lvl = 1'($urandom_range(0, 1));
    it.sel = 4'($urandom_range(0, 8));
    it.data = random_word();
    if (pick < 45) begin
      it.kind = KIND_LINE;
    end else if (pick < 70) begin
      it.kind = KIND_WRITE;
      it.sel = (pick < 67) ? 4'($urandom_range(0, 6)) : 4'($urandom_range(7, 15));
    end else if (pick < 96) begin
      it.kind = KIND_READ;
      if (pick >= 93) it.sel = 4'($urandom_range(9, 15));
    end else begin
      it.kind = KIND_NONE;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string field, input logic [DataW-1:0] want,
                                 input logic [DataW-1:0] got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Offer one transfer after a random gap, hold it until taken, then predict.
  task automatic send_item(input item_t it, input logic known, input result_t typed);
    int unsigned gap;
    result_t     predicted;
    if (sent_count % 32 == 0) src_burst = ($urandom_range(0, 3) == 0);
    gap = src_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i       <= it.kind;
    line_index_i <= it.idx;
    line_level_i <= it.lvl;
    reg_select_i <= it.sel;
    write_data_i <= it.data;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = step_controller(it);
    results_due.push_back(known ? typed : predicted);
    sent_count++;
  endtask

  // Drop valid and wait until every result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write line_invert over APB, then read it back. Loads the level mirror too.
  task automatic set_line_invert(input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LineInvertAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    invert_mirror = value;
    levels_mirror = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) report_mismatch("line_invert readback", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall a random number of cycles before each transfer, with
  // stretches of back-to-back readiness.
  initial begin : result_sink
    int unsigned hold;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (taken_count % 40 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      hold = sink_burst ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
      taken_count++;
    end
  end

  // Compare each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        report_mismatch("read_data of unexpected result", '0, read_data_o);
      end else begin
        want = results_due.pop_front();
        if (read_data_o !== want.rd) report_mismatch("read_data", want.rd, read_data_o);
        if (critical_irq_o !== want.crit)
          report_mismatch("critical_irq", DataW'(want.crit), DataW'(critical_irq_o));
        if (noncritical_irq_o !== want.noncrit)
          report_mismatch("noncritical_irq", DataW'(want.noncrit), DataW'(noncritical_irq_o));
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("** vectored_interrupt_controller_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [DataW-1:0] invert_setting;
    mismatches   = 0;
    sent_count   = 0;
    taken_count  = 0;
    src_burst    = 1'b0;
    sink_burst   = 1'b0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= KIND_NONE;
    line_index_i <= '0;
    line_level_i <= 1'b0;
    reg_select_i <= '0;
    write_data_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;

    // Reset values of the mirror.
    invert_mirror   = '0;
    status_mirror   = '0;
    enable_mirror   = '0;
    critical_mirror = '0;
    polarity_mirror = AllOnes;
    trigger_mirror  = TriggerReset;
    veccfg_mirror   = '0;
    levels_mirror   = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the opening table.
    foreach (opening_rows[r])
      send_item(opening_rows[r].it, opening_rows[r].known, opening_rows[r].exp);

    // Random phases, each under its own inversion mask: all ones, random, zero,
    // random. Reconfigure only once the controller has gone quiet.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: invert_setting = AllOnes;
        2: invert_setting = '0;
        default: invert_setting = $urandom;
      endcase
      drain();
      set_line_invert(invert_setting);
      repeat (RandomPerPhase) send_item(random_item(), 1'b0, NoIrq);
    end

    // Wait out the last results, then let the result register settle.
    drain();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("** vectored_interrupt_controller_top: PASSED **");
    end else begin
      $display("** vectored_interrupt_controller_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/vic_pkg.sv
hdl/vectored_interrupt_controller_top.sv
hdl/vic_checker.sv
bench/tb_vectored_interrupt_controller_top.sv
